// ===== sv/nfcs_pkg.sv =====
package nfcs_pkg;

  // field widths
  localparam int ADDR_W   = 18;
  localparam int DATA_W   = 16;
  localparam int CMD_W    = 3;
  localparam int UNIT_W   = 7;
  localparam int LIMIT_W  = 25;
  localparam int STABLE_W = 3;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int STEP_W   = 3;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W = 1;

  // flash geometry in words
  localparam int SECTOR_WORDS = 2048;
  localparam int BLOCK_WORDS  = 32768;
  localparam int CHIP_WORDS   = 262144;
  localparam int LEN_W        = $clog2(CHIP_WORDS + 1);

  localparam logic [LEN_W-1:0]  SECTOR_LEN     = LEN_W'(SECTOR_WORDS);
  localparam logic [LEN_W-1:0]  BLOCK_LEN      = LEN_W'(BLOCK_WORDS);
  localparam logic [LEN_W-1:0]  CHIP_LEN       = LEN_W'(CHIP_WORDS);
  localparam logic [ADDR_W-1:0] CHIP_LAST_ADDR = ADDR_W'(CHIP_WORDS - 1);

  // host command codes
  localparam logic [CMD_W-1:0] CMD_SECTOR_ERASE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BLOCK_ERASE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHIP_ERASE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PROGRAM      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ         = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESPONSE     = 3'd5;

  // bus access codes
  localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // completion status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_VERIFY_ERR = 2'd2;

  // result kinds chosen by the controller
  localparam logic [KIND_W-1:0] K_HOST      = 3'd0;
  localparam logic [KIND_W-1:0] K_RD_TARGET = 3'd1;
  localparam logic [KIND_W-1:0] K_RD_VERIFY = 3'd2;
  localparam logic [KIND_W-1:0] K_DONE      = 3'd3;
  localparam logic [KIND_W-1:0] K_DONE_READ = 3'd4;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_READS = 1'b1;
  localparam logic [LIMIT_W-1:0]   POLL_LIMIT_RST   = 25'h1000000;
  localparam logic [STABLE_W-1:0]  STABLE_READS_RST = 3'd5;

  // unlock addresses and data words
  localparam logic [ADDR_W-1:0] UNLOCK_ADDR1 = 18'h05555;
  localparam logic [ADDR_W-1:0] UNLOCK_ADDR2 = 18'h02AAA;
  localparam logic [DATA_W-1:0] ERASE_KEY1   = 16'hAAAA;
  localparam logic [DATA_W-1:0] ERASE_KEY2   = 16'h5555;
  localparam logic [DATA_W-1:0] ERASE_SETUP  = 16'h8080;
  localparam logic [DATA_W-1:0] SECTOR_GO    = 16'h3030;
  localparam logic [DATA_W-1:0] BLOCK_GO     = 16'h5050;
  localparam logic [DATA_W-1:0] CHIP_GO      = 16'h1010;
  localparam logic [DATA_W-1:0] PROG_KEY1    = 16'h00AA;
  localparam logic [DATA_W-1:0] PROG_KEY2    = 16'h0055;
  localparam logic [DATA_W-1:0] PROG_SETUP   = 16'h00A0;
  localparam logic [DATA_W-1:0] ERASED_WORD  = 16'hFFFF;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [UNIT_W-1:0] unit_number;
    logic [ADDR_W-1:0] word_offset;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] read_data;
    logic              last_word;
  } in_item_t;

  typedef struct packed {
    logic [OP_W-1:0]     bus_op;
    logic [ADDR_W-1:0]   bus_address;
    logic [DATA_W-1:0]   bus_data;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_value;
    logic                run_last;
    logic                last_result;
  } res_item_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_acc_t;

  // controller to datapath
  typedef struct packed {
    logic                latch;
    logic                host;
    logic [STEP_W-1:0]   step;
    logic                poll_erase;
    logic                poll_prog;
    logic                pair_first;
    logic                to_verify;
    logic                to_verify_chip;
    logic                verify_step;
    logic                load;
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic                run_last;
    logic                last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             good;
    logic             pair_half;
    logic             limit_hit;
    logic             stable_erase;
    logic             stable_prog;
    logic             verify_last;
    logic             out_free;
  } dp_stat_t;

  // bus access for one step of a host command sequence
  function automatic bus_acc_t host_access(input logic [CMD_W-1:0]  cmd,
                                           input logic [STEP_W-1:0] step,
                                           input logic [ADDR_W-1:0] target,
                                           input logic [DATA_W-1:0] wdata);
    bus_acc_t acc;
    acc = '{op: OP_NONE, addr: '0, data: '0};
    if (cmd == CMD_READ) begin
      acc = '{op: OP_READ, addr: target, data: '0};
    end else if (cmd == CMD_PROGRAM) begin
      case (step)
        3'd0:    acc = '{op: OP_WRITE, addr: UNLOCK_ADDR1, data: PROG_KEY1};
        3'd1:    acc = '{op: OP_WRITE, addr: UNLOCK_ADDR2, data: PROG_KEY2};
        3'd2:    acc = '{op: OP_WRITE, addr: UNLOCK_ADDR1, data: PROG_SETUP};
        3'd3:    acc = '{op: OP_WRITE, addr: target, data: wdata};
        default: acc = '{op: OP_READ, addr: target, data: '0};
      endcase
    end else begin
      case (step)
        3'd0:    acc = '{op: OP_WRITE, addr: UNLOCK_ADDR1, data: ERASE_KEY1};
        3'd1:    acc = '{op: OP_WRITE, addr: UNLOCK_ADDR2, data: ERASE_KEY2};
        3'd2:    acc = '{op: OP_WRITE, addr: UNLOCK_ADDR1, data: ERASE_SETUP};
        3'd3:    acc = '{op: OP_WRITE, addr: UNLOCK_ADDR1, data: ERASE_KEY1};
        3'd4:    acc = '{op: OP_WRITE, addr: UNLOCK_ADDR2, data: ERASE_KEY2};
        3'd5: begin
          if (cmd == CMD_SECTOR_ERASE) begin
            acc = '{op: OP_WRITE, addr: target, data: SECTOR_GO};
          end else if (cmd == CMD_BLOCK_ERASE) begin
            acc = '{op: OP_WRITE, addr: target, data: BLOCK_GO};
          end else begin
            acc = '{op: OP_WRITE, addr: UNLOCK_ADDR1, data: CHIP_GO};
          end
        end
        default: acc = '{op: OP_READ, addr: target, data: '0};
      endcase
    end
    return acc;
  endfunction

endpackage

// ===== sv/nfcs_dp.sv =====
module nfcs_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nfcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nfcs_pkg::LIMIT_W-1:0]   cfg_data,
  input  nfcs_pkg::in_item_t             cmd_item,
  input  logic                           res_stall,
  output logic                           res_valid,
  output nfcs_pkg::res_item_t            res_item,
  input  nfcs_pkg::ctrl_cmd_t            ctl,
  output nfcs_pkg::dp_stat_t             st
);

  logic [nfcs_pkg::LIMIT_W-1:0]  poll_limit;
  logic [nfcs_pkg::STABLE_W-1:0] stable_reads;
  nfcs_pkg::in_item_t            item;
  logic [nfcs_pkg::ADDR_W-1:0]   target;
  logic [nfcs_pkg::ADDR_W-1:0]   target_next;
  logic [nfcs_pkg::LEN_W-1:0]    verify_index;
  logic [nfcs_pkg::LEN_W-1:0]    verify_index_next;
  logic [nfcs_pkg::LEN_W-1:0]    verify_length;
  logic [nfcs_pkg::LEN_W-1:0]    verify_length_next;
  logic [nfcs_pkg::DATA_W-1:0]   first_of_pair;
  logic                          pair_half;
  logic                          held_last_word;
  logic [nfcs_pkg::STABLE_W-1:0] stable_count;
  logic [nfcs_pkg::STABLE_W-1:0] stable_count_next;
  logic [nfcs_pkg::LIMIT_W-1:0]  poll_count;
  logic [nfcs_pkg::LIMIT_W-1:0]  poll_count_next;
  nfcs_pkg::res_item_t           res_next;

  logic                          good_ff;
  logic                          pair_eq;
  logic                          limit_hit;
  logic [nfcs_pkg::STABLE_W-1:0] need;
  logic [nfcs_pkg::STABLE_W-1:0] stable_inc;
  logic [nfcs_pkg::STABLE_W-1:0] stable_erase_val;
  logic [nfcs_pkg::STABLE_W-1:0] stable_prog_val;
  logic [nfcs_pkg::LEN_W-1:0]    verify_inc;
  logic [nfcs_pkg::LEN_W-1:0]    verify_sum;
  logic [31:0]                   sector_base;
  logic [31:0]                   block_base;
  nfcs_pkg::bus_acc_t            acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit   <= nfcs_pkg::POLL_LIMIT_RST;
      stable_reads <= nfcs_pkg::STABLE_READS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nfcs_pkg::CFG_POLL_LIMIT:   poll_limit   <= cfg_data;
        nfcs_pkg::CFG_STABLE_READS: stable_reads <= cfg_data[nfcs_pkg::STABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // poll checks
  assign good_ff    = (item.read_data == nfcs_pkg::ERASED_WORD);
  assign pair_eq    = (item.read_data == first_of_pair);
  assign limit_hit  = (poll_count >= poll_limit);
  assign need       = (stable_reads == '0) ? nfcs_pkg::STABLE_W'(1) : stable_reads;
  assign stable_inc = (stable_count == '1) ? stable_count : stable_count + 1'b1;
  assign stable_erase_val = good_ff ? stable_inc : '0;
  assign stable_prog_val  = pair_eq ? stable_inc : '0;
  assign verify_inc = verify_index + 1'b1;

  // erase region bases
  assign sector_base = 32'(item.unit_number) * 32'(nfcs_pkg::SECTOR_WORDS);
  assign block_base  = 32'(item.unit_number) * 32'(nfcs_pkg::BLOCK_WORDS);

  // next state of the sequence registers
  always_comb begin
    target_next        = target;
    verify_length_next = verify_length;
    if (ctl.host) begin
      case (item.cmd)
        nfcs_pkg::CMD_SECTOR_ERASE: begin
          target_next        = sector_base[nfcs_pkg::ADDR_W-1:0];
          verify_length_next = nfcs_pkg::SECTOR_LEN;
        end
        nfcs_pkg::CMD_BLOCK_ERASE: begin
          target_next        = block_base[nfcs_pkg::ADDR_W-1:0];
          verify_length_next = nfcs_pkg::BLOCK_LEN;
        end
        nfcs_pkg::CMD_CHIP_ERASE: begin
          target_next        = nfcs_pkg::CHIP_LAST_ADDR;
          verify_length_next = nfcs_pkg::CHIP_LEN;
        end
        default: target_next = item.word_offset;
      endcase
    end else if (ctl.to_verify && ctl.to_verify_chip) begin
      target_next = '0;
    end

    verify_index_next = verify_index;
    if (ctl.to_verify) begin
      verify_index_next = '0;
    end else if (ctl.verify_step) begin
      verify_index_next = verify_inc;
    end

    stable_count_next = stable_count;
    poll_count_next   = poll_count;
    if (ctl.host) begin
      stable_count_next = '0;
      poll_count_next   = '0;
    end else if (ctl.poll_erase || ctl.poll_prog) begin
      stable_count_next = ctl.poll_erase ? stable_erase_val : stable_prog_val;
      poll_count_next   = limit_hit ? poll_count : poll_count + 1'b1;
    end
  end

  assign verify_sum = {{(nfcs_pkg::LEN_W - nfcs_pkg::ADDR_W){1'b0}}, target}
                      + verify_index_next;
  assign acc = nfcs_pkg::host_access(item.cmd, ctl.step, target_next, item.write_data);

  // result fields
  always_comb begin
    res_next             = '0;
    res_next.last_result = ctl.last;
    case (ctl.kind)
      nfcs_pkg::K_HOST: begin
        res_next.bus_op      = acc.op;
        res_next.bus_address = acc.addr;
        res_next.bus_data    = acc.data;
      end
      nfcs_pkg::K_RD_TARGET: begin
        res_next.bus_op      = nfcs_pkg::OP_READ;
        res_next.bus_address = target_next;
      end
      nfcs_pkg::K_RD_VERIFY: begin
        res_next.bus_op      = nfcs_pkg::OP_READ;
        res_next.bus_address = verify_sum[nfcs_pkg::ADDR_W-1:0];
      end
      nfcs_pkg::K_DONE_READ: begin
        res_next.done_res   = 1'b1;
        res_next.status     = ctl.status;
        res_next.read_value = item.read_data;
        res_next.run_last   = ctl.run_last & held_last_word;
      end
      default: begin
        res_next.done_res = 1'b1;
        res_next.status   = ctl.status;
        res_next.run_last = ctl.run_last & held_last_word;
      end
    endcase
  end

  // sequence registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target         <= '0;
      verify_index   <= '0;
      verify_length  <= '0;
      first_of_pair  <= '0;
      pair_half      <= 1'b0;
      held_last_word <= 1'b0;
      stable_count   <= '0;
      poll_count     <= '0;
    end else begin
      target        <= target_next;
      verify_index  <= verify_index_next;
      verify_length <= verify_length_next;
      stable_count  <= stable_count_next;
      poll_count    <= poll_count_next;
      if (ctl.host) begin
        held_last_word <= item.last_word;
      end
      if (ctl.pair_first) begin
        first_of_pair <= item.read_data;
      end
      if (ctl.pair_first) begin
        pair_half <= 1'b1;
      end else if (ctl.host || ctl.poll_prog) begin
        pair_half <= 1'b0;
      end
    end
  end

  // input item holding register
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item <= cmd_item;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_item <= res_next;
    end
  end

  // status to the controller
  assign st.cmd          = item.cmd;
  assign st.good         = good_ff;
  assign st.pair_half    = pair_half;
  assign st.limit_hit    = limit_hit;
  assign st.stable_erase = (stable_erase_val >= need);
  assign st.stable_prog  = (stable_prog_val >= need);
  assign st.verify_last  = (verify_inc >= verify_length);
  assign st.out_free     = !res_valid || !res_stall;

endmodule

// ===== sv/nfcs_ctrl.sv =====
module nfcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  nfcs_pkg::dp_stat_t  st,
  output nfcs_pkg::ctrl_cmd_t ctl
);

  // sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // operation phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_ERASE_POLL = 3'd1;
  localparam logic [2:0] PH_CHIP_POLL  = 3'd2;
  localparam logic [2:0] PH_VERIFY     = 3'd3;
  localparam logic [2:0] PH_PROG_POLL  = 3'd4;
  localparam logic [2:0] PH_READ_WAIT  = 3'd5;

  // index of the last bus access of each host sequence
  localparam logic [nfcs_pkg::STEP_W-1:0] ERASE_LAST = 3'd6;
  localparam logic [nfcs_pkg::STEP_W-1:0] PROG_LAST  = 3'd4;

  logic                          state;
  logic                          state_next;
  logic [2:0]                    phase;
  logic [2:0]                    phase_next;
  logic [nfcs_pkg::STEP_W-1:0]   step;
  logic [nfcs_pkg::STEP_W-1:0]   step_next;
  logic [nfcs_pkg::STEP_W-1:0]   n_last;
  logic [nfcs_pkg::STEP_W-1:0]   n_last_next;

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    ctl         = '0;
    state_next  = state;
    phase_next  = phase;
    step_next   = step;
    n_last_next = n_last;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_EXEC;
          step_next  = '0;
        end
      end
      S_EXEC: begin
        ctl.step = step;
        if (step != '0) begin
          // remaining accesses of a host sequence
          if (st.out_free) begin
            ctl.load  = 1'b1;
            ctl.kind  = nfcs_pkg::K_HOST;
            step_next = step + 1'b1;
            if (step == n_last) begin
              ctl.last   = 1'b1;
              state_next = S_IDLE;
            end
          end
        end else if (st.cmd <= nfcs_pkg::CMD_READ) begin
          // host command: dropped while an operation runs
          if (phase != PH_IDLE) begin
            state_next = S_IDLE;
          end else if (st.out_free) begin
            ctl.host  = 1'b1;
            ctl.load  = 1'b1;
            ctl.kind  = nfcs_pkg::K_HOST;
            step_next = step + 1'b1;
            case (st.cmd)
              nfcs_pkg::CMD_SECTOR_ERASE, nfcs_pkg::CMD_BLOCK_ERASE: begin
                phase_next  = PH_ERASE_POLL;
                n_last_next = ERASE_LAST;
              end
              nfcs_pkg::CMD_CHIP_ERASE: begin
                phase_next  = PH_CHIP_POLL;
                n_last_next = ERASE_LAST;
              end
              nfcs_pkg::CMD_PROGRAM: begin
                phase_next  = PH_PROG_POLL;
                n_last_next = PROG_LAST;
              end
              default: begin
                phase_next = PH_READ_WAIT;
                ctl.last   = 1'b1;
                state_next = S_IDLE;
              end
            endcase
          end
        end else if (st.cmd == nfcs_pkg::CMD_RESPONSE && phase != PH_IDLE) begin
          // bus read response: exactly one result
          if (st.out_free) begin
            ctl.load   = 1'b1;
            ctl.last   = 1'b1;
            state_next = S_IDLE;
            case (phase)
              PH_ERASE_POLL, PH_CHIP_POLL: begin
                ctl.poll_erase = 1'b1;
                if (st.limit_hit) begin
                  ctl.kind   = nfcs_pkg::K_DONE;
                  ctl.status = nfcs_pkg::ST_TIMEOUT;
                  phase_next = PH_IDLE;
                end else if (st.stable_erase) begin
                  ctl.to_verify      = 1'b1;
                  ctl.to_verify_chip = (phase == PH_CHIP_POLL);
                  ctl.kind           = nfcs_pkg::K_RD_TARGET;
                  phase_next         = PH_VERIFY;
                end else begin
                  ctl.kind = nfcs_pkg::K_RD_TARGET;
                end
              end
              PH_VERIFY: begin
                if (!st.good) begin
                  ctl.kind   = nfcs_pkg::K_DONE;
                  ctl.status = nfcs_pkg::ST_VERIFY_ERR;
                  phase_next = PH_IDLE;
                end else begin
                  ctl.verify_step = 1'b1;
                  if (st.verify_last) begin
                    ctl.kind   = nfcs_pkg::K_DONE;
                    ctl.status = nfcs_pkg::ST_OK;
                    phase_next = PH_IDLE;
                  end else begin
                    ctl.kind = nfcs_pkg::K_RD_VERIFY;
                  end
                end
              end
              PH_PROG_POLL: begin
                if (!st.pair_half) begin
                  ctl.pair_first = 1'b1;
                  ctl.kind       = nfcs_pkg::K_RD_TARGET;
                end else begin
                  ctl.poll_prog = 1'b1;
                  if (st.limit_hit) begin
                    ctl.kind     = nfcs_pkg::K_DONE;
                    ctl.status   = nfcs_pkg::ST_TIMEOUT;
                    ctl.run_last = 1'b1;
                    phase_next   = PH_IDLE;
                  end else if (st.stable_prog) begin
                    ctl.kind     = nfcs_pkg::K_DONE;
                    ctl.status   = nfcs_pkg::ST_OK;
                    ctl.run_last = 1'b1;
                    phase_next   = PH_IDLE;
                  end else begin
                    ctl.kind = nfcs_pkg::K_RD_TARGET;
                  end
                end
              end
              PH_READ_WAIT: begin
                ctl.kind     = nfcs_pkg::K_DONE_READ;
                ctl.status   = nfcs_pkg::ST_OK;
                ctl.run_last = 1'b1;
                phase_next   = PH_IDLE;
              end
              default: begin
                ctl.load = 1'b0;
                ctl.last = 1'b0;
              end
            endcase
          end
        end else begin
          // stray response or unknown command
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      phase  <= PH_IDLE;
      step   <= '0;
      n_last <= '0;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      step   <= step_next;
      n_last <= n_last_next;
    end
  end

endmodule

// ===== sv/nor_flash_command_sequencer_top.sv =====
// NOR flash command sequencer for a 16-bit parallel JEDEC flash.
// Input channel (cmd_valid / cmd_stall / cmd_item) carries host commands
// (sector, block or chip erase, program word, read word) and the flash
// data for each pending bus read. Output channel (res_valid / res_stall /
// res_item) carries bus accesses and completions; last_result marks the
// final result of an input item.
// An item is held in an input register, then its results leave one per
// cycle through the output register: an erase command gives 7 results, a
// program command 5, a read command and a read response 1 each. An item
// holds the input side until its last result is loaded; a command that is
// dropped (busy, stray response, unknown code) gives nothing. The
// controller steps one result per cycle; that sets the rate.
// While the receiver stalls, the output register holds its result and the
// sequence waits; the input side stays stalled until the item is finished.
// The user writes configuration (poll_limit, stable_reads) through cfg_we,
// cfg_index, cfg_data only while no item is in progress; not enforced here.
// Synchronous reset returns to idle, empties the output register and loads
// poll_limit = 0x1000000 and stable_reads = 5.
module nor_flash_command_sequencer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  nfcs_pkg::in_item_t             cmd_item,
  output logic                           res_valid,
  input  logic                           res_stall,
  output nfcs_pkg::res_item_t            res_item,
  input  logic                           cfg_we,
  input  logic [nfcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nfcs_pkg::LIMIT_W-1:0]   cfg_data
);

  nfcs_pkg::ctrl_cmd_t ctl;
  nfcs_pkg::dp_stat_t  st;

  // sequencing and phase control
  nfcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .st        (st),
    .ctl       (ctl)
  );

  // counters, addresses and output register
  nfcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_item  (cmd_item),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_item  (res_item),
    .ctl       (ctl),
    .st        (st)
  );

endmodule

// ===== sv/nfcs_chk.sv =====
module nfcs_chk (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input logic                res_valid,
  input logic                res_stall,
  input nfcs_pkg::res_item_t res_item
);

  // a stalled result stays valid
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res_item))
    else $error("result changed while stalled");

  // a completion always ends the results of its item
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.done_res |-> res_item.last_result)
    else $error("completion not marked last");

  // every result is a bus access or a completion
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.bus_op == nfcs_pkg::OP_NONE |-> res_item.done_res)
    else $error("empty result without completion");

  // one item at a time: an accepted item blocks the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("input not held after accept");

endmodule

bind nor_flash_command_sequencer_top nfcs_chk u_chk (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import nfcs_pkg::*;

  // command codes the block must drop
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam int DRAIN_SLACK = 8;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEMS_PER_SETTING = 55;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ERASE_POLL,
    SEQ_CHIP_POLL,
    SEQ_VERIFY,
    SEQ_PROG_POLL,
    SEQ_READ_WAIT
  } seq_phase_e;

  logic        clk;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  in_item_t    cmd_item = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_item_t   res_item;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  // sequencer state as the testbench sees it
  seq_phase_e          ph = SEQ_IDLE;
  logic [2:0]          stable_cnt = '0;
  logic [LIMIT_W-1:0]  poll_cnt = '0;
  logic [ADDR_W-1:0]   target = '0;
  logic [LEN_W-1:0]    vidx = '0;
  logic [LEN_W-1:0]    vlen = '0;
  logic [DATA_W-1:0]   pair_first = '0;
  logic                pair_half = 1'b0;
  logic                held_last = 1'b0;
  logic [LIMIT_W-1:0]  poll_limit_r = POLL_LIMIT_RST;
  logic [STABLE_W-1:0] stable_need = STABLE_READS_RST;

  // results of one accepted item, then the queue of results still to come
  res_item_t step_out [7];
  int        step_cnt;
  res_item_t due_results [$];

  bit jitter = 1'b1;
  int hold_request = 0;
  int mismatches = 0;
  int results_checked = 0;
  int items_with_results = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  nor_flash_command_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // ---------------------------------------------------------------------
  // prediction

  function automatic void emit(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                               logic [DATA_W-1:0] d);
    res_item_t r;
    r = '0;
    r.bus_op = op;
    r.bus_address = a;
    r.bus_data = d;
    step_out[step_cnt] = r;
    step_cnt++;
  endfunction

  function automatic void complete(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] rv,
                                   logic rl);
    res_item_t r;
    r = '0;
    r.bus_op = OP_NONE;
    r.done_res = 1'b1;
    r.status = st;
    r.read_value = rv;
    r.run_last = rl;
    step_out[step_cnt] = r;
    step_cnt++;
    ph = SEQ_IDLE;
  endfunction

  function automatic void start_poll(seq_phase_e p);
    ph = p;
    stable_cnt = '0;
    poll_cnt = '0;
    pair_half = 1'b0;
  endfunction

  // count one poll; stability is updated before the limit is checked
  function automatic bit poll_exhausted(bit good);
    if (good) begin
      if (stable_cnt != 3'd7) stable_cnt = stable_cnt + 3'd1;
    end else begin
      stable_cnt = '0;
    end
    if (poll_cnt >= poll_limit_r) return 1'b1;
    poll_cnt = poll_cnt + 1'b1;
    return 1'b0;
  endfunction

  // zero stable_reads acts as one
  function automatic bit settled();
    return stable_cnt >= ((stable_need == '0) ? 3'd1 : stable_need);
  endfunction

  function automatic int sequence_step(in_item_t it);
    int                unit_idx;
    logic [ADDR_W-1:0] go_addr;
    logic [DATA_W-1:0] go_word;
    step_cnt = 0;
    unit_idx = int'(it.unit_number);
    if (it.cmd <= CMD_READ && ph == SEQ_IDLE) begin
      if (it.cmd == CMD_PROGRAM) begin
        target = it.word_offset;
        held_last = it.last_word;
        emit(OP_WRITE, UNLOCK_ADDR1, PROG_KEY1);
        emit(OP_WRITE, UNLOCK_ADDR2, PROG_KEY2);
        emit(OP_WRITE, UNLOCK_ADDR1, PROG_SETUP);
        emit(OP_WRITE, it.word_offset, it.write_data);
        emit(OP_READ, it.word_offset, '0);
        start_poll(SEQ_PROG_POLL);
      end else if (it.cmd == CMD_READ) begin
        target = it.word_offset;
        held_last = it.last_word;
        emit(OP_READ, it.word_offset, '0);
        ph = SEQ_READ_WAIT;
      end else begin
        // erase: region base and length, then the unlock writes
        case (it.cmd)
          CMD_SECTOR_ERASE: begin
            target = ADDR_W'(unit_idx * SECTOR_WORDS);
            vlen = SECTOR_LEN;
            go_addr = target;
            go_word = SECTOR_GO;
          end
          CMD_BLOCK_ERASE: begin
            target = ADDR_W'(unit_idx * BLOCK_WORDS);
            vlen = BLOCK_LEN;
            go_addr = target;
            go_word = BLOCK_GO;
          end
          default: begin
            target = CHIP_LAST_ADDR;
            vlen = CHIP_LEN;
            go_addr = UNLOCK_ADDR1;
            go_word = CHIP_GO;
          end
        endcase
        emit(OP_WRITE, UNLOCK_ADDR1, ERASE_KEY1);
        emit(OP_WRITE, UNLOCK_ADDR2, ERASE_KEY2);
        emit(OP_WRITE, UNLOCK_ADDR1, ERASE_SETUP);
        emit(OP_WRITE, UNLOCK_ADDR1, ERASE_KEY1);
        emit(OP_WRITE, UNLOCK_ADDR2, ERASE_KEY2);
        emit(OP_WRITE, go_addr, go_word);
        emit(OP_READ, target, '0);
        if (it.cmd == CMD_CHIP_ERASE) start_poll(SEQ_CHIP_POLL);
        else start_poll(SEQ_ERASE_POLL);
      end
    end else if (it.cmd == CMD_RESPONSE) begin
      case (ph)
        SEQ_ERASE_POLL, SEQ_CHIP_POLL: begin
          if (poll_exhausted(it.read_data == ERASED_WORD)) begin
            complete(ST_TIMEOUT, '0, 1'b0);
          end else begin
            if (settled()) begin
              if (ph == SEQ_CHIP_POLL) target = '0;
              vidx = '0;
              ph = SEQ_VERIFY;
            end
            emit(OP_READ, target, '0);
          end
        end
        SEQ_VERIFY: begin
          if (it.read_data != ERASED_WORD) begin
            complete(ST_VERIFY_ERR, '0, 1'b0);
          end else begin
            vidx = vidx + 1'b1;
            if (vidx >= vlen) complete(ST_OK, '0, 1'b0);
            else emit(OP_READ, ADDR_W'(target + vidx), '0);
          end
        end
        SEQ_PROG_POLL: begin
          if (!pair_half) begin
            pair_first = it.read_data;
            pair_half = 1'b1;
            emit(OP_READ, target, '0);
          end else begin
            pair_half = 1'b0;
            if (poll_exhausted(pair_first == it.read_data)) complete(ST_TIMEOUT, '0, held_last);
            else if (settled()) complete(ST_OK, '0, held_last);
            else emit(OP_READ, target, '0);
          end
        end
        SEQ_READ_WAIT: complete(ST_OK, it.read_data, held_last);
        default: ;
      endcase
    end
    if (step_cnt > 0) step_out[step_cnt - 1].last_result = 1'b1;
    for (int i = 0; i < step_cnt; i++) due_results.push_back(step_out[i]);
    return step_cnt;
  endfunction

  // ---------------------------------------------------------------------
  // item construction and driving

  function automatic in_item_t host_item(logic [CMD_W-1:0] c, logic [UNIT_W-1:0] u,
                                         logic [ADDR_W-1:0] o, logic [DATA_W-1:0] w,
                                         logic l);
    in_item_t it;
    it.cmd = c;
    it.unit_number = u;
    it.word_offset = o;
    it.write_data = w;
    it.read_data = DATA_W'($urandom);
    it.last_word = l;
    return it;
  endfunction

  function automatic in_item_t resp_item(logic [DATA_W-1:0] d);
    in_item_t it;
    it = host_item(CMD_RESPONSE, UNIT_W'($urandom), ADDR_W'($urandom),
                   DATA_W'($urandom), 1'($urandom));
    it.read_data = d;
    return it;
  endfunction

  // a host command the busy block drops, or an unused code
  function automatic in_item_t noise_item();
    in_item_t it;
    it = host_item(CMD_W'($urandom_range(0, 4)), UNIT_W'($urandom), ADDR_W'($urandom),
                   DATA_W'($urandom), 1'($urandom));
    if (chance(40)) it.cmd = chance(50) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    return it;
  endfunction

  // valid stays high after acceptance until the next item or a drain
  task automatic send_item(in_item_t it);
    int gap;
    gap = jitter ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item <= it;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (sequence_step(it) > 0) items_with_results++;
  endtask

  task automatic command(logic [CMD_W-1:0] c, logic [UNIT_W-1:0] u,
                         logic [ADDR_W-1:0] o, logic [DATA_W-1:0] w, logic l);
    send_item(host_item(c, u, o, w, l));
  endtask

  task automatic reply(logic [DATA_W-1:0] d);
    send_item(resp_item(d));
  endtask

  task automatic wait_drain();
    cmd_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLL_LIMIT) poll_limit_r = val;
    else stable_need = val[STABLE_W-1:0];
    cfg_writes++;
    @(posedge clk);
  endtask

  // flash answers that mostly let the sequence progress
  task automatic answer_until_idle(int verify_good_pct);
    logic [DATA_W-1:0] d;
    while (ph != SEQ_IDLE) begin
      case (ph)
        SEQ_ERASE_POLL, SEQ_CHIP_POLL: d = chance(75) ? ERASED_WORD : DATA_W'($urandom);
        SEQ_VERIFY: d = chance(verify_good_pct) ? ERASED_WORD
                                                : DATA_W'($urandom_range(0, 16'hFFFE));
        SEQ_PROG_POLL: d = (pair_half && chance(75)) ? pair_first : DATA_W'($urandom);
        default: d = DATA_W'($urandom);
      endcase
      if (chance(6)) send_item(noise_item());
      reply(d);
    end
  endtask

  task automatic launch_random_command();
    int       pick;
    in_item_t it;
    pick = $urandom_range(0, 99);
    it = host_item(CMD_READ, UNIT_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom),
                   1'($urandom));
    if (pick < 30) it.cmd = CMD_READ;
    else if (pick < 60) it.cmd = CMD_PROGRAM;
    else if (pick < 75) it.cmd = CMD_SECTOR_ERASE;
    else if (pick < 85) it.cmd = CMD_BLOCK_ERASE;
    else if (pick < 93) it.cmd = CMD_CHIP_ERASE;
    else if (pick < 97) it = resp_item(DATA_W'($urandom));
    else it.cmd = pick[0] ? CMD_UNUSED_6 : CMD_UNUSED_7;
    send_item(it);
  endtask

  // ---------------------------------------------------------------------
  // tests

  // extremes of every field, every command, dropped items
  task automatic test_directed();
    write_cfg(CFG_POLL_LIMIT, POLL_LIMIT_RST);
    write_cfg(CFG_STABLE_READS, LIMIT_W'(1));
    command(CMD_READ, '1, '1, '1, 1'b1);
    reply(ERASED_WORD);
    command(CMD_READ, '0, '0, '0, 1'b0);
    reply('0);
    // unequal pair first, then a matching one
    command(CMD_PROGRAM, '0, '1, '1, 1'b1);
    reply(16'h1234);
    reply(16'h1235);
    reply(16'hAAAA);
    reply(16'hAAAA);
    // busy command is dropped
    command(CMD_PROGRAM, '1, '0, '0, 1'b0);
    command(CMD_READ, '1, '1, '1, 1'b1);
    reply('0);
    reply('0);
    // stray response and unused codes while idle
    reply(16'h5555);
    command(CMD_UNUSED_6, '1, '1, '1, 1'b1);
    command(CMD_UNUSED_7, '0, '0, '0, 1'b0);
    // sector erase: a bad poll, a good one, then a failed verify
    command(CMD_SECTOR_ERASE, '1, '0, '0, 1'b0);
    reply('0);
    reply(ERASED_WORD);
    reply(16'h1234);
    // block base wraps past the top of the flash
    command(CMD_BLOCK_ERASE, '1, '0, '0, 1'b0);
    reply(ERASED_WORD);
    reply(ERASED_WORD);
    reply(16'hFFFE);
    // chip erase verify starts at word zero
    command(CMD_CHIP_ERASE, '0, '1, '1, 1'b1);
    reply(ERASED_WORD);
    reply('0);
  endtask

  // poll limit and stable count corners
  task automatic test_poll_limits();
    wait_drain();
    write_cfg(CFG_POLL_LIMIT, '0);
    write_cfg(CFG_STABLE_READS, '0);
    command(CMD_PROGRAM, UNIT_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom), 1'b1);
    reply(16'h00FF);
    reply(16'h00FF);
    command(CMD_SECTOR_ERASE, '0, '0, '0, 1'b0);
    reply(ERASED_WORD);
    // timeout wins over stability on the same poll
    wait_drain();
    write_cfg(CFG_POLL_LIMIT, LIMIT_W'(2));
    write_cfg(CFG_STABLE_READS, LIMIT_W'(3));
    command(CMD_BLOCK_ERASE, '0, '0, '0, 1'b0);
    repeat (3) reply(ERASED_WORD);
    wait_drain();
    write_cfg(CFG_POLL_LIMIT, '1);
    write_cfg(CFG_STABLE_READS, LIMIT_W'(7));
    command(CMD_SECTOR_ERASE, UNIT_W'(64), '0, '0, 1'b0);
    repeat (6) reply(ERASED_WORD);
    reply('0);
    repeat (7) reply(ERASED_WORD);
    reply(16'h7FFF);
    command(CMD_PROGRAM, '0, ADDR_W'($urandom), DATA_W'($urandom), 1'b0);
    reply(16'h0005);
    reply(16'h0006);
    repeat (7) begin
      reply(16'hC3C3);
      reply(16'hC3C3);
    end
    wait_drain();
    write_cfg(CFG_POLL_LIMIT, LIMIT_W'(1));
    write_cfg(CFG_STABLE_READS, LIMIT_W'(1));
    command(CMD_CHIP_ERASE, '0, '0, '0, 1'b0);
    reply('0);
    reply('0);
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    wait_drain();
    write_cfg(CFG_POLL_LIMIT, POLL_LIMIT_RST);
    write_cfg(CFG_STABLE_READS, LIMIT_W'(2));
    jitter = 1'b0;
    hold_request = 400;
    repeat (12) begin
      command(CMD_READ, UNIT_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom),
              1'($urandom));
      reply(DATA_W'($urandom));
    end
    // sender waits for every result before going on
    wait_drain();
    hold_request = 250;
    repeat (2) begin
      command(CMD_PROGRAM, UNIT_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom),
              1'($urandom));
      answer_until_idle(85);
    end
    wait_drain();
    jitter = 1'b1;
  endtask

  // random sequences under several register settings
  task automatic test_random_traffic();
    logic [LIMIT_W-1:0]  lim;
    logic [STABLE_W-1:0] need;
    int                  goal;
    for (int setting = 0; setting < 6; setting++) begin
      case (setting)
        0: begin lim = LIMIT_W'(1); need = 3'd7; end
        1: begin lim = '1; need = 3'd0; end
        2: begin lim = LIMIT_W'($urandom_range(2, 40)); need = STABLE_W'($urandom_range(1, 7)); end
        3: begin lim = '0; need = 3'd3; end
        4: begin lim = LIMIT_W'($urandom_range(3, 20)); need = STABLE_W'($urandom_range(0, 7)); end
        default: begin lim = POLL_LIMIT_RST; need = 3'd1; end
      endcase
      wait_drain();
      write_cfg(CFG_POLL_LIMIT, lim);
      write_cfg(CFG_STABLE_READS, LIMIT_W'({$urandom_range(0, 4194303), need}));
      jitter = (setting != 2);
      goal = items_with_results + ITEMS_PER_SETTING;
      while (items_with_results < goal) begin
        launch_random_command();
        answer_until_idle(85);
        if (chance(12)) wait_drain();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // result side: random stall per item, long hold-off on request

  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = jitter ? $urandom_range(0, 13) : 0;
      end
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch in %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // compare each accepted result with the oldest one due
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got 0x%h", $time, res_item);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        results_checked++;
        check_field("bus_op", want.bus_op, res_item.bus_op);
        check_field("bus_address", want.bus_address, res_item.bus_address);
        check_field("bus_data", want.bus_data, res_item.bus_data);
        check_field("done_res", want.done_res, res_item.done_res);
        check_field("status", want.status, res_item.status);
        check_field("read_value", want.read_value, res_item.read_value);
        check_field("run_last", want.run_last, res_item.run_last);
        check_field("last_result", want.last_result, res_item.last_result);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t timeout: no handshake for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, due_results.size());
        $display("[nor_flash_command_sequencer_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_poll_limits();
    test_backpressure();
    test_random_traffic();
    wait_drain();
    $display("covered all commands, dropped items, poll limits, verify failures, backpressure");
    $display("%0d items with results, %0d results checked, %0d register writes",
             items_with_results, results_checked, cfg_writes);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("[nor_flash_command_sequencer_top] OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, due_results.size());
      $display("[nor_flash_command_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nfcs_pkg.sv
sv/nfcs_dp.sv
sv/nfcs_ctrl.sv
sv/nor_flash_command_sequencer_top.sv
sv/nfcs_chk.sv
tb/sv/tb.sv
